### hw/rtl/assert_macros.svh
// assertion macros shared by the deque rtl
// no dependencies; define ASSERT_OFF to compile the checks out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: invariant violated");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)

`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### hw/rtl/deq_pkg.sv
// types and constants for the double-ended queue
// used by deq_cell, deq_ctrl and double_ended_queue
package deq_pkg;

   localparam int DATA_W = 32;

   typedef enum logic [2:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_WALK_FWD   = 3'd4,
      CMD_WALK_BWD   = 3'd5,
      CMD_COUNT      = 3'd6
   } cmd_type;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH_FRONT,
      CELL_PUSH_BACK,
      CELL_POP_FRONT,
      CELL_POP_BACK,
      CELL_ROT_FWD,
      CELL_ROT_BWD
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] push_value;
   } cell_ctrl_type;

   typedef enum logic {
      CTRL_IDLE,
      CTRL_WALK
   } ctrl_state_type;

endpackage

### hw/rtl/deq_cell.sv
// one storage cell of the deque chain: an entry and its occupied flag
// depends on deq_pkg
module deq_cell
   import deq_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  cell_ctrl_type            ctrl,
   input  logic signed [DATA_W-1:0] left_data,
   input  logic                     left_occ,
   input  logic signed [DATA_W-1:0] right_data,
   input  logic                     right_occ,
   input  logic signed [DATA_W-1:0] head_data,
   output logic signed [DATA_W-1:0] data_out,
   output logic                     occ_out
);

   logic signed [DATA_W-1:0] data_ff, data_in;
   logic                     occ_ff, occ_in;
   logic                     is_last;

   // occupied cells form an unbroken run from the front
   assign is_last = occ_ff & ~right_occ;

   always_comb begin
      data_in = data_ff;
      occ_in  = occ_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_PUSH_FRONT: begin
            data_in = left_data;
            occ_in  = left_occ;
         end
         CELL_PUSH_BACK: begin
            if (!occ_ff && left_occ) begin
               data_in = ctrl.push_value;
               occ_in  = 1'b1;
            end
         end
         CELL_POP_FRONT: begin
            data_in = right_data;
            occ_in  = right_occ;
         end
         CELL_POP_BACK: begin
            if (is_last) begin
               occ_in = 1'b0;
            end
         end
         CELL_ROT_FWD: begin
            if (occ_ff) begin
               data_in = is_last ? head_data : right_data;
            end
         end
         CELL_ROT_BWD: begin
            // the front cell sees the tail on its left input
            if (occ_ff) begin
               data_in = left_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   assign occ_out  = occ_ff;

endmodule

### hw/rtl/deq_ctrl.sv
// command sequencer and result register of the deque
// depends on deq_pkg and assert_macros.svh
`include "assert_macros.svh"

module deq_ctrl
   import deq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_command,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value_out,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_occupancy,
   output logic                     rsp_last_of_run,
   input  logic signed [DATA_W-1:0] head_data,
   input  logic signed [DATA_W-1:0] tail_data,
   output cell_ctrl_type            cell_ctrl
);

   ctrl_state_type           state_ff, state_in;
   logic                     walk_fwd_ff, walk_fwd_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic [CNT_W-1:0]         count_ff, count_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_value_ff, rsp_value_in;
   logic [1:0]               rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]         rsp_occ_ff, rsp_occ_in;
   logic                     rsp_last_ff, rsp_last_in;

   logic    out_free, accept, is_full, is_empty, is_walk, emit;
   logic    pop_on_empty, empty_rsp_held;
   cmd_type cmd;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == CTRL_IDLE) && out_free;
   assign accept    = req_valid && req_ready;
   assign cmd       = cmd_type'(req_command);
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);
   assign is_walk   = (cmd == CMD_WALK_FWD) || (cmd == CMD_WALK_BWD);

   assign pop_on_empty   = accept && is_empty &&
                           ((cmd == CMD_POP_FRONT) || (cmd == CMD_POP_BACK));
   assign empty_rsp_held = rsp_valid_ff && (rsp_status_ff == STATUS_EMPTY) && rsp_last_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (accept && is_walk && !is_empty) begin
               state_in = CTRL_WALK;
            end
         end
         CTRL_WALK: begin
            if (out_free && remain_ff == CNT_W'(1)) begin
               state_in = CTRL_IDLE;
            end
         end
         default: state_in = CTRL_IDLE;
      endcase
   end

   // outputs and datapath control
   always_comb begin
      cell_ctrl.op         = CELL_HOLD;
      cell_ctrl.push_value = req_value_in;
      emit                 = 1'b0;
      rsp_value_in         = '0;
      rsp_status_in        = STATUS_OK;
      rsp_last_in          = 1'b1;
      count_in             = count_ff;
      walk_fwd_in          = walk_fwd_ff;
      remain_in            = remain_ff;
      unique case (state_ff)
         CTRL_IDLE: begin
            if (accept) begin
               emit = 1'b1;
               unique case (cmd)
                  CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                     if (is_full) begin
                        rsp_status_in = STATUS_FULL;
                     end else begin
                        cell_ctrl.op = (cmd == CMD_PUSH_FRONT) ? CELL_PUSH_FRONT
                                                               : CELL_PUSH_BACK;
                        count_in     = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_POP_FRONT, CMD_POP_BACK: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else if (cmd == CMD_POP_FRONT) begin
                        cell_ctrl.op = CELL_POP_FRONT;
                        rsp_value_in = head_data;
                        count_in     = count_ff - CNT_W'(1);
                     end else begin
                        cell_ctrl.op = CELL_POP_BACK;
                        rsp_value_in = tail_data;
                        count_in     = count_ff - CNT_W'(1);
                     end
                  end
                  CMD_WALK_FWD, CMD_WALK_BWD: begin
                     if (is_empty) begin
                        rsp_status_in = STATUS_EMPTY;
                     end else begin
                        // results come one per cycle from the walk state while the output register is free
                        emit        = 1'b0;
                        walk_fwd_in = (cmd == CMD_WALK_FWD);
                        remain_in   = count_ff;
                     end
                  end
                  CMD_COUNT: begin
                  end
                  default: begin
                  end
               endcase
            end
         end
         CTRL_WALK: begin
            if (out_free) begin
               emit         = 1'b1;
               // rotating the chain count times leaves it as it was
               cell_ctrl.op = walk_fwd_ff ? CELL_ROT_FWD : CELL_ROT_BWD;
               rsp_value_in = walk_fwd_ff ? head_data : tail_data;
               rsp_last_in  = (remain_ff == CNT_W'(1));
               remain_in    = remain_ff - CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
      rsp_occ_in   = count_in;
      rsp_valid_in = emit ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= CTRL_IDLE;
         count_ff     <= '0;
         remain_ff    <= '0;
         walk_fwd_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
         walk_fwd_ff  <= walk_fwd_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
         rsp_occ_ff    <= rsp_occ_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_out   = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_occupancy   = rsp_occ_ff;
   assign rsp_last_of_run = rsp_last_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(DEPTH))
   `ASSERT_ALWAYS(a_walk_blocks_req, clock, reset, (state_ff != CTRL_WALK) || !req_ready)
   `ASSERT_ALWAYS(a_walk_remain, clock, reset, (state_ff != CTRL_WALK) || (remain_ff != '0))
   `ASSERT_NEXT(a_pop_empty, clock, reset, pop_on_empty, empty_rsp_held)

endmodule

### hw/rtl/double_ended_queue.sv
// Bounded double-ended queue of signed 32-bit entries held in a row of DEPTH
// cells, the front entry always in the first cell. Push, pop and count give
// one result each; the next item is taken while the result register is
// being emptied. A walk of a non-empty queue gives one result per stored
// entry, during which the chain rotates by one cell per result and no item
// is taken; after the walk the chain is back in its original order. Results
// wait in a single output register, so a stalled rsp_ready holds input off.
// Pushes onto a full queue are dropped with a full status. There is no
// clearing pass after reset: entries read only once written.
// Depends on deq_pkg, deq_cell and deq_ctrl.
module double_ended_queue
   import deq_pkg::*;
#(
   parameter int DEPTH = 16,
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [2:0]               req_command,
   input  logic signed [DATA_W-1:0] req_value_in,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_value_out,
   output logic [1:0]               rsp_status,
   output logic [CNT_W-1:0]         rsp_occupancy,
   output logic                     rsp_last_of_run
);

   cell_ctrl_type            cell_ctrl;
   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic [DEPTH-1:0]         cell_occ;
   logic [DEPTH-1:0]         tail_hit;
   logic signed [DATA_W-1:0] tail_data;
   logic signed [DATA_W-1:0] front_feed;

   // last occupied cell, one-hot
   assign tail_hit = cell_occ & ~(cell_occ >> 1);

   always_comb begin
      tail_data = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_data = tail_data | (cell_data[i] & {DATA_W{tail_hit[i]}});
      end
   end

   // the front cell loads a pushed value or, on a backward rotate, the tail
   assign front_feed = (cell_ctrl.op == CELL_PUSH_FRONT) ? cell_ctrl.push_value : tail_data;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_data, right_data;
      logic                     left_occ, right_occ;

      if (i == 0) begin : g_first
         assign left_data = front_feed;
         assign left_occ  = 1'b1;
      end else begin : g_inner_l
         assign left_data = cell_data[i-1];
         assign left_occ  = cell_occ[i-1];
      end

      if (i == DEPTH - 1) begin : g_final
         assign right_data = '0;
         assign right_occ  = 1'b0;
      end else begin : g_inner_r
         assign right_data = cell_data[i+1];
         assign right_occ  = cell_occ[i+1];
      end

      deq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .left_data  (left_data),
         .left_occ   (left_occ),
         .right_data (right_data),
         .right_occ  (right_occ),
         .head_data  (cell_data[0]),
         .data_out   (cell_data[i]),
         .occ_out    (cell_occ[i])
      );
   end

   deq_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_command     (req_command),
      .req_value_in    (req_value_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_value_out   (rsp_value_out),
      .rsp_status      (rsp_status),
      .rsp_occupancy   (rsp_occupancy),
      .rsp_last_of_run (rsp_last_of_run),
      .head_data       (cell_data[0]),
      .tail_data       (tail_data),
      .cell_ctrl       (cell_ctrl)
   );

endmodule
